/* hdl/sensor_power_read_sequencer_core_macros.svh */
// Assertion helpers for the sensor power read sequencer.
`ifndef SENSOR_POWER_READ_SEQUENCER_CORE_MACROS_SVH
`define SENSOR_POWER_READ_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SPRS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SPRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/sprs_pkg.sv */
package sprs_pkg;

	localparam int unsigned TEMP_W  = 12;
	localparam int unsigned DELAY_W = 16;
	localparam int unsigned RETRY_W = 8;
	localparam int unsigned QUAL_W  = 2;
	localparam int unsigned ADDR_W  = 5;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned IN_TDATA_W  = 16;
	localparam int unsigned OUT_TDATA_W = 24;

	localparam logic [DELAY_W-1:0] TIMER_MAX = '1;

	// Register indexes (byte address / 4)
	localparam logic [2:0] REG_POWER_ON_DELAY = 3'd0;
	localparam logic [2:0] REG_READ_DELAY     = 3'd1;
	localparam logic [2:0] REG_MIN_VALID_TEMP = 3'd2;
	localparam logic [2:0] REG_MAX_VALID_TEMP = 3'd3;
	localparam logic [2:0] REG_RETRY_LIMIT    = 3'd4;

	// Reset values of the registers
	localparam logic [DELAY_W-1:0]       RST_POWER_ON_DELAY = 16'd10;
	localparam logic [DELAY_W-1:0]       RST_READ_DELAY     = 16'd20;
	localparam logic signed [TEMP_W-1:0] RST_MIN_VALID_TEMP = -12'sd880;
	localparam logic signed [TEMP_W-1:0] RST_MAX_VALID_TEMP = 12'sd2000;
	localparam logic [RETRY_W-1:0]       RST_RETRY_LIMIT    = 8'd3;

	typedef enum logic {
		PHASE_WAIT = 1'b0,
		PHASE_READ = 1'b1
	} phase_t;

	typedef enum logic [1:0] {
		STEP_FIRST   = 2'd0,
		STEP_SECOND  = 2'd1,
		STEP_COMPUTE = 2'd2,
		STEP_UNUSED  = 2'd3
	} step_t;

	typedef enum logic [QUAL_W-1:0] {
		QUAL_INIT    = 2'd0,
		QUAL_GOOD    = 2'd1,
		QUAL_FAILING = 2'd2,
		QUAL_BAD     = 2'd3
	} quality_t;

	typedef struct packed {
		quality_t                  quality;
		logic signed [TEMP_W-1:0]  temperature;
		logic                      result_done;
		logic                      sample_taken;
		logic                      sensor_power;
	} result_t;

endpackage

/* hdl/sensor_power_read_sequencer_core.sv */
// A result is registered before it shows on m_tvalid. Throughput: one request per cycle
// while the skid register is empty; a two-entry output stage (result register plus skid
// register) keeps s_tready registered and absorbs one stalled result.
// Reset (arst_n low, asynchronous): registers back to 10, 20, -880, 2000, 3;
// timer 1, wait phase, power off, readings and published temperature 0, quality init.
`include "sensor_power_read_sequencer_core_macros.svh"

module sensor_power_read_sequencer_core
	import sprs_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// APB configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready,
	// request stream
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_TDATA_W-1:0]    s_tdata,   // [0] tick, [12:1] sample, [15:13] zero
	// result stream
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_TDATA_W-1:0]   m_tdata    // [0] sensor_power, [1] sample_taken,
	                                            // [2] result_done, [14:3] temperature,
	                                            // [16:15] quality, [23:17] zero
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [DELAY_W-1:0]       power_on_delay_q;
	logic [DELAY_W-1:0]       read_delay_q;
	logic signed [TEMP_W-1:0] min_valid_temp_q;
	logic signed [TEMP_W-1:0] max_valid_temp_q;
	logic [RETRY_W-1:0]       retry_limit_q;

	logic       cfg_wr;
	logic [2:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_on_delay_q <= RST_POWER_ON_DELAY;
			read_delay_q     <= RST_READ_DELAY;
			min_valid_temp_q <= RST_MIN_VALID_TEMP;
			max_valid_temp_q <= RST_MAX_VALID_TEMP;
			retry_limit_q    <= RST_RETRY_LIMIT;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_POWER_ON_DELAY: power_on_delay_q <= pwdata[DELAY_W-1:0];
				REG_READ_DELAY:     read_delay_q     <= pwdata[DELAY_W-1:0];
				REG_MIN_VALID_TEMP: min_valid_temp_q <= pwdata[TEMP_W-1:0];
				REG_MAX_VALID_TEMP: max_valid_temp_q <= pwdata[TEMP_W-1:0];
				REG_RETRY_LIMIT:    retry_limit_q    <= pwdata[RETRY_W-1:0];
				default: ;  // addresses past the last register: drop the write
			endcase
		end
	end

	// Readback; signed limits come back sign-extended
	always_comb begin
		unique case (cfg_idx)
			REG_POWER_ON_DELAY: prdata = {{(DATA_W-DELAY_W){1'b0}}, power_on_delay_q};
			REG_READ_DELAY:     prdata = {{(DATA_W-DELAY_W){1'b0}}, read_delay_q};
			REG_MIN_VALID_TEMP: prdata = {{(DATA_W-TEMP_W){min_valid_temp_q[TEMP_W-1]}},
			                              min_valid_temp_q};
			REG_MAX_VALID_TEMP: prdata = {{(DATA_W-TEMP_W){max_valid_temp_q[TEMP_W-1]}},
			                              max_valid_temp_q};
			REG_RETRY_LIMIT:    prdata = {{(DATA_W-RETRY_W){1'b0}}, retry_limit_q};
			default:            prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer state
	// ------------------------------------------------------------------
	phase_t                   phase_q, phase_d;
	step_t                    step_q, step_d;
	logic [DELAY_W-1:0]       timer_q, timer_d;
	logic [RETRY_W-1:0]       retry_q, retry_d;
	logic signed [TEMP_W-1:0] value_q [2];
	logic signed [TEMP_W-1:0] value_d [2];
	logic [1:0]               good_q, good_d;
	logic                     power_q, power_d;
	logic signed [TEMP_W-1:0] pub_temp_q, pub_temp_d;
	quality_t                 pub_qual_q, pub_qual_d;

	// Request fields
	logic                     in_tick;
	logic signed [TEMP_W-1:0] in_sample;
	logic                     in_acc;

	assign in_tick   = s_tdata[0];
	assign in_sample = s_tdata[TEMP_W:1];
	assign in_acc    = s_tvalid & s_tready;

	// Per-pass scratch
	logic [DELAY_W-1:0]       timer_inc;
	logic                     slot;
	logic                     in_range;
	logic [RETRY_W-1:0]       retry_inc;
	logic signed [TEMP_W:0]   sum;
	logic                     taken;
	logic                     done;
	result_t                  res;

	always_comb begin
		phase_d    = phase_q;
		step_d     = step_q;
		retry_d    = retry_q;
		value_d    = value_q;
		good_d     = good_q;
		power_d    = power_q;
		pub_temp_d = pub_temp_q;
		pub_qual_d = pub_qual_q;
		taken      = 1'b0;
		done       = 1'b0;

		// Saturating tick timer, runs in both phases
		timer_inc = (in_tick && timer_q != TIMER_MAX) ? timer_q + 1'b1 : timer_q;
		timer_d   = timer_inc;

		slot      = step_q[0];
		in_range  = (in_sample >= min_valid_temp_q) && (in_sample <= max_valid_temp_q);
		retry_inc = retry_q + 1'b1;
		sum       = {value_q[0][TEMP_W-1], value_q[0]} + {value_q[1][TEMP_W-1], value_q[1]};

		if (phase_q == PHASE_WAIT) begin
			// power check first: power may rise on the same pass that leaves wait
			if (timer_inc >= power_on_delay_q)
				power_d = 1'b1;
			if (timer_inc >= read_delay_q) begin
				timer_d = '0;
				phase_d = PHASE_READ;
			end
		end else begin
			unique case (step_q)
				STEP_FIRST, STEP_SECOND: begin
					taken = 1'b1;
					if (in_range) begin
						value_d[slot] = in_sample;
						good_d[slot]  = 1'b1;
						retry_d       = '0;
						step_d        = step_t'(step_q + 2'd1);
					end else begin
						// keep the stale value, only clear its good bit
						good_d[slot] = 1'b0;
						if (retry_inc >= retry_limit_q) begin
							retry_d = '0;
							step_d  = step_t'(step_q + 2'd1);
						end else begin
							retry_d = retry_inc;
						end
					end
				end
				STEP_COMPUTE: begin
					phase_d = PHASE_WAIT;
					step_d  = STEP_FIRST;
					power_d = 1'b0;
					done    = 1'b1;
					if (good_q == 2'b00) begin
						// bad: hold the old temperature
						pub_qual_d = QUAL_BAD;
					end else begin
						// floor of half sum is an arithmetic shift of the 13-bit sum
						pub_temp_d = sum[TEMP_W:1];
						pub_qual_d = (good_q == 2'b11) ? QUAL_GOOD : QUAL_FAILING;
					end
				end
				default: ;  // unreachable step: the pass does nothing
			endcase
		end

		res.sensor_power = power_d;
		res.sample_taken = taken;
		res.result_done  = done;
		res.temperature  = pub_temp_d;
		res.quality      = pub_qual_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PHASE_WAIT;
			step_q     <= STEP_FIRST;
			timer_q    <= 16'd1;
			retry_q    <= '0;
			value_q[0] <= '0;
			value_q[1] <= '0;
			good_q     <= '0;
			power_q    <= 1'b0;
			pub_temp_q <= '0;
			pub_qual_q <= QUAL_INIT;
		end else if (in_acc) begin
			phase_q    <= phase_d;
			step_q     <= step_d;
			timer_q    <= timer_d;
			retry_q    <= retry_d;
			value_q    <= value_d;
			good_q     <= good_d;
			power_q    <= power_d;
			pub_temp_q <= pub_temp_d;
			pub_qual_q <= pub_qual_d;
		end
	end

	// ------------------------------------------------------------------
	// Output stage: result register plus one skid entry
	// ------------------------------------------------------------------
	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    out_take;
	logic    out_free;

	assign out_take = m_tvalid & m_tready;
	assign out_free = ~out_valid_q | out_take;
	// hold off new requests only while the skid entry is occupied
	assign s_tready = ~skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				// advance the skid entry first; it is older than any new request
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q  <= in_acc;
				end
			end else if (in_acc) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (in_acc)
				out_q <= res;
		end else if (in_acc) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W-$bits(result_t)){1'b0}}, out_q};

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`SPRS_ASSERT_NOW(a_skid_implies_out, skid_valid_q, out_valid_q,
		"skid entry held while result register empty")
	`SPRS_ASSERT_NOW(a_wait_idle_counters, phase_q == PHASE_WAIT,
		step_q == STEP_FIRST && retry_q == '0, "read step or retry count left over in wait")
	`SPRS_ASSERT_NOW(a_done_powers_off, m_tvalid && m_tdata[2],
		!m_tdata[0] && !m_tdata[1], "compute result with power on or sample taken")
	`SPRS_ASSERT_NEXT(a_compute_returns, in_acc && phase_q == PHASE_READ
		&& step_q == STEP_COMPUTE, phase_q == PHASE_WAIT && !power_q,
		"compute pass did not return to wait with power off")

endmodule

/* tb/sensor_power_read_sequencer_core_checker.sv */
module sensor_power_read_sequencer_core_checker
	import sprs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic                   pready,
	input  logic [ADDR_W-1:0]      paddr,
	input  logic [DATA_W-1:0]      pwdata,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] tick, [12:1] sample
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,   // [0] power, [1] taken, [2] done,
	                                          // [14:3] temperature, [16:15] quality
	output int unsigned            fail_count,
	output int unsigned            pending
);

	// Register copies
	logic [DELAY_W-1:0]       power_on_delay;
	logic [DELAY_W-1:0]       read_delay;
	logic signed [TEMP_W-1:0] min_temp;
	logic signed [TEMP_W-1:0] max_temp;
	logic [RETRY_W-1:0]       retry_limit;

	// Sequencer state
	phase_t                   phase;
	step_t                    step;
	logic [DELAY_W-1:0]       timer;
	logic [RETRY_W-1:0]       retries;
	logic signed [TEMP_W-1:0] reading [2];
	logic                     reading_ok [2];
	logic                     power;
	logic signed [TEMP_W-1:0] pub_temp;
	quality_t                 pub_quality;

	result_t                  expected_passes [$];
	result_t                  got;
	result_t                  want;
	int unsigned              mismatches = 0;

	assign fail_count = mismatches;

	// One main-loop pass: update the state and return what the block must show.
	function automatic result_t next_pass_result(input logic tick,
			input logic signed [TEMP_W-1:0] smp);
		logic                   taken;
		logic                   done;
		logic signed [TEMP_W:0] sum;
		result_t                r;
		taken = 1'b0;
		done  = 1'b0;
		if (tick && timer != TIMER_MAX)
			timer = timer + 1'b1;
		if (phase == PHASE_WAIT) begin
			// power check first, so both may happen in one pass
			if (timer >= power_on_delay)
				power = 1'b1;
			if (timer >= read_delay) begin
				timer = '0;
				phase = PHASE_READ;
			end
		end else if (step == STEP_FIRST || step == STEP_SECOND) begin
			taken = 1'b1;
			if (smp >= min_temp && smp <= max_temp) begin
				reading[step[0]]    = smp;
				reading_ok[step[0]] = 1'b1;
				retries             = '0;
				step                = step_t'(step + 2'd1);
			end else begin
				// keep the stale value, drop only the good flag
				reading_ok[step[0]] = 1'b0;
				retries             = retries + 1'b1;
				if (retries >= retry_limit) begin
					retries = '0;
					step    = step_t'(step + 2'd1);
				end
			end
		end else if (step == STEP_COMPUTE) begin
			phase = PHASE_WAIT;
			step  = STEP_FIRST;
			power = 1'b0;
			done  = 1'b1;
			if (!reading_ok[0] && !reading_ok[1]) begin
				pub_quality = QUAL_BAD;
			end else begin
				sum         = reading[0] + reading[1];
				pub_temp    = sum[TEMP_W:1];
				pub_quality = (reading_ok[0] && reading_ok[1]) ? QUAL_GOOD : QUAL_FAILING;
			end
		end
		r.sensor_power = power;
		r.sample_taken = taken;
		r.result_done  = done;
		r.temperature  = pub_temp;
		r.quality      = pub_quality;
		return r;
	endfunction

	task automatic check_field(input string field, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, got %0d",
				$time, field, exp_val, act_val);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_on_delay = RST_POWER_ON_DELAY;
			read_delay     = RST_READ_DELAY;
			min_temp       = RST_MIN_VALID_TEMP;
			max_temp       = RST_MAX_VALID_TEMP;
			retry_limit    = RST_RETRY_LIMIT;
			phase          = PHASE_WAIT;
			step           = STEP_FIRST;
			timer          = 16'd1;
			retries        = '0;
			reading[0]     = '0;
			reading[1]     = '0;
			reading_ok[0]  = 1'b0;
			reading_ok[1]  = 1'b0;
			power          = 1'b0;
			pub_temp       = '0;
			pub_quality    = QUAL_INIT;
			expected_passes.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_POWER_ON_DELAY: power_on_delay = pwdata[DELAY_W-1:0];
					REG_READ_DELAY:     read_delay     = pwdata[DELAY_W-1:0];
					REG_MIN_VALID_TEMP: min_temp       = pwdata[TEMP_W-1:0];
					REG_MAX_VALID_TEMP: max_temp       = pwdata[TEMP_W-1:0];
					REG_RETRY_LIMIT:    retry_limit    = pwdata[RETRY_W-1:0];
					default: ;
				endcase
			end
			// a result never leaves in the cycle its request enters, so pop first
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[16:0]);
				if (expected_passes.size() == 0) begin
					mismatches++;
					$display("%0t: result with no request outstanding, expected none, got %h",
						$time, m_tdata);
				end else begin
					want = expected_passes.pop_front();
					check_field("sensor_power", want.sensor_power, got.sensor_power);
					check_field("sample_taken", want.sample_taken, got.sample_taken);
					check_field("result_done", want.result_done, got.result_done);
					check_field("temperature", want.temperature, got.temperature);
					check_field("quality", want.quality, got.quality);
				end
			end
			if (s_tvalid && s_tready)
				expected_passes.push_back(next_pass_result(s_tdata[0], s_tdata[12:1]));
			pending <= expected_passes.size();
		end
	end

endmodule

/* tb/sensor_power_read_sequencer_core_tb.sv */
module sensor_power_read_sequencer_core_tb;
	import sprs_pkg::*;

	localparam int unsigned CYCLE_LIMIT     = 400000;
	localparam int unsigned HOLD_OFF_CYCLES = 40;
	localparam int unsigned NUM_REGS        = 5;
	localparam int unsigned ROUNDS          = 12;
	localparam int unsigned ROUND_REQUESTS  = 140;
	// enough ticks to walk the timer past both delays, plus the read passes
	localparam int unsigned LONG_WAIT_REQUESTS = 40;

	logic                   clk;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [ADDR_W-1:0]      paddr;
	logic [DATA_W-1:0]      pwdata;
	logic [DATA_W-1:0]      prdata;
	logic                   pready;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;    // [0] tick, [12:1] sample, [15:13] zero
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;    // [0] sensor_power, [1] sample_taken,
	                                    // [2] result_done, [14:3] temperature,
	                                    // [16:15] quality, [23:17] zero

	int unsigned fail_count;
	int unsigned pending;
	int unsigned cycle_count = 0;

	// Random idling on both sides while set; cleared for the equal-delay test and the last round.
	logic idle_on      = 1'b1;
	// Raised by the stimulus to ask the result side for one long hold-off.
	logic hold_off_req = 1'b0;

	// Valid window currently programmed, used to aim samples at its edges.
	logic signed [TEMP_W-1:0] cur_min = RST_MIN_VALID_TEMP;
	logic signed [TEMP_W-1:0] cur_max = RST_MAX_VALID_TEMP;

	sensor_power_read_sequencer_core dut (.*);

	sensor_power_read_sequencer_core_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Count cycles and cut the run off if it hangs.
	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	// Result side: hold m_tready low for random bursts, or for one long stretch
	// on request so the output stage fills and the block pushes back on requests.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
				hold_off_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Write all registers through the APB port: setup cycle, then access cycle.
	// Call only while nothing is outstanding.
	task automatic program_config(input logic [DELAY_W-1:0] power_delay,
			input logic [DELAY_W-1:0] start_delay,
			input logic signed [TEMP_W-1:0] lo, input logic signed [TEMP_W-1:0] hi,
			input logic [RETRY_W-1:0] limit);
		logic [DATA_W-1:0] value [NUM_REGS];
		logic [2:0]        index [NUM_REGS];
		index = '{REG_POWER_ON_DELAY, REG_READ_DELAY, REG_MIN_VALID_TEMP,
			REG_MAX_VALID_TEMP, REG_RETRY_LIMIT};
		// temperatures go out sign-extended to the full bus
		value = '{DATA_W'(power_delay), DATA_W'(start_delay), DATA_W'(lo), DATA_W'(hi),
			DATA_W'(limit)};
		cur_min = lo;
		cur_max = hi;
		for (int i = 0; i < NUM_REGS; i++) begin
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b1;
			paddr   <= {index[i], 2'b00};
			pwdata  <= value[i];
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Offer one request and return at the edge that accepts it. Leave s_tvalid
	// high so back-to-back requests need only one assignment per edge.
	task automatic send_request(input logic tick, input logic signed [TEMP_W-1:0] smp);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, smp, tick};
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop offering and wait until every result has come back, then let the pipeline settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (3) @(posedge clk);
	endtask

	// Mostly samples inside the window and on its edges, some noise.
	function automatic logic signed [TEMP_W-1:0] random_sample();
		case ($urandom_range(0, 11))
			0:       return 12'sh800;
			1:       return 12'sh7FF;
			2:       return cur_min;
			3:       return cur_max;
			4:       return cur_min - 12'sd1;
			5:       return cur_max + 12'sd1;
			6:       return TEMP_W'($urandom);
			default: begin
				if (cur_min <= cur_max)
					return cur_min + TEMP_W'($urandom_range(0, int'(cur_max) - int'(cur_min)));
				else
					return TEMP_W'($urandom);
			end
		endcase
	endfunction

	initial begin
		int unsigned              tick_pct;
		logic [DELAY_W-1:0]       power_delay;
		logic [DELAY_W-1:0]       start_delay;
		logic signed [TEMP_W-1:0] lo;
		logic signed [TEMP_W-1:0] hi;
		logic signed [TEMP_W-1:0] swap;
		logic [RETRY_W-1:0]       limit;

		arst_n   <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Both delays zero: power and reading start in the same pass; the readings
		// are the sample extremes, so the compute pass rounds -1/2 down.
		program_config(16'd0, 16'd0, 12'sh800, 12'sh7FF, 8'd1);
		send_request(1'b0, 12'sd0);
		send_request(1'b1, 12'sh800);
		send_request(1'b0, 12'sh7FF);
		send_request(1'b1, 12'sd5);
		drain();

		// Narrow window, two attempts: first reading retried then good, second
		// reading fails twice and gives up, so the result averages in the stale slot.
		program_config(16'd0, 16'd0, 12'sd100, 12'sd200, 8'd2);
		send_request(1'b0, 12'sd0);
		send_request(1'b1, 12'sd50);
		send_request(1'b1, 12'sd150);
		send_request(1'b0, 12'sd300);
		send_request(1'b0, -12'sd5);
		send_request(1'b1, 12'sd0);
		drain();

		// Empty window with a zero retry limit: each reading gives up at once and
		// the result is bad, leaving the published temperature alone.
		program_config(16'd0, 16'd0, 12'sd300, 12'sd200, 8'd0);
		send_request(1'b0, 12'sd0);
		send_request(1'b1, 12'sd250);
		send_request(1'b0, 12'sd250);
		send_request(1'b1, 12'sd0);
		drain();

		// Read delay below power delay; the first request has no tick, but the timer left over
		// from the last test already meets both delays, so power and reading start together.
		program_config(16'd2, 16'd1, RST_MIN_VALID_TEMP, RST_MAX_VALID_TEMP, 8'd3);
		send_request(1'b0, 12'sd0);
		send_request(1'b1, 12'sd0);
		send_request(1'b0, 12'sd2000);
		send_request(1'b1, -12'sd880);
		send_request(1'b0, 12'sd0);
		drain();

		// Equal delays: tick the timer up with no idling, so power and reading
		// start together at the same count.
		idle_on = 1'b0;
		program_config(16'd30, 16'd30, 12'sh800, 12'sh7FF, 8'd255);
		for (int i = 0; i < LONG_WAIT_REQUESTS; i++)
			send_request(1'b1, random_sample());
		drain();
		idle_on = 1'b1;

		// Random rounds: the reset settings first, then random settings; the last
		// round runs without idling.
		for (int round_idx = 0; round_idx < ROUNDS; round_idx++) begin
			if (round_idx == 0) begin
				program_config(RST_POWER_ON_DELAY, RST_READ_DELAY, RST_MIN_VALID_TEMP,
					RST_MAX_VALID_TEMP, RST_RETRY_LIMIT);
			end else begin
				power_delay = ($urandom_range(0, 9) == 0) ? 16'hFFFF : DELAY_W'($urandom_range(0, 12));
				start_delay = DELAY_W'($urandom_range(0, 12));
				lo = TEMP_W'($urandom);
				hi = TEMP_W'($urandom);
				// keep most windows well formed; an empty one now and then
				if (lo > hi && $urandom_range(0, 7) != 0) begin
					swap = lo;
					lo   = hi;
					hi   = swap;
				end
				if ($urandom_range(0, 5) == 0) begin
					lo = 12'sh800;
					hi = 12'sh7FF;
				end
				case ($urandom_range(0, 9))
					0:       limit = 8'd255;
					1:       limit = 8'd1;
					default: limit = RETRY_W'($urandom_range(1, 4));
				endcase
				program_config(power_delay, start_delay, lo, hi, limit);
			end
			idle_on  = (round_idx != ROUNDS - 1);
			tick_pct = $urandom_range(30, 100);
			for (int i = 0; i < ROUND_REQUESTS; i++) begin
				// hold the result side off while requests keep coming
				if (round_idx == 2 && i == 20)
					hold_off_req = 1'b1;
				// pause requests until every result is back, mid-sequence
				if (round_idx == 4 && i == 70)
					drain();
				send_request($urandom_range(1, 100) <= tick_pct, random_sample());
			end
			drain();
		end

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
